/* hdl/assert_macros.svh */
// assertion helpers for the rtl files; the top filter file includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/caf_pkg.sv */
`default_nettype none

package caf_pkg;

   // table size
   localparam int RULES_DEFAULT = 16;

   // request kinds carried on tuser
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_CHECK = 1'b1;

   // address families on the request
   localparam logic [1:0] FAM_V4 = 2'd0;
   localparam logic [1:0] FAM_V6 = 2'd1;

   // stored rule family
   localparam logic RULE_V4 = 1'b0;
   localparam logic RULE_V6 = 1'b1;

   // prefix limits
   localparam logic [7:0] V4_MAX_PREFIX = 8'd32;
   localparam logic [7:0] V6_MAX_PREFIX = 8'd128;

   // upper half of the low word of a v4-mapped ipv6 address
   localparam logic [31:0] V4_MAPPED_TAG = 32'h0000_FFFF;

   typedef enum logic [1:0] {
      MODE_DISABLED     = 2'd0,
      MODE_ALLOW_EXCEPT = 2'd1,
      MODE_DENY_EXCEPT  = 2'd2,
      MODE_UNKNOWN      = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESP
   } state_type;

   // which rules a check is matched against
   typedef enum logic [1:0] {
      CLS_V4,
      CLS_V6,
      CLS_NONE
   } cls_type;

   typedef struct packed {
      logic        family;
      logic [7:0]  prefix;
      logic [63:0] net_hi;
      logic [63:0] net_lo;
   } rule_type;

   typedef struct packed {
      logic    entry_valid;
      cls_type cls;
   } match_ctrl_type;

endpackage

`default_nettype wire

/* hdl/caf_ram.sv */
`default_nettype none

module caf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = caf_pkg::RULES_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/caf_match.sv */
`default_nettype none

module caf_match (
   input  wire caf_pkg::match_ctrl_type ctrl,
   input  wire caf_pkg::rule_type       rule,
   input  wire logic [63:0]             addr_hi,
   input  wire logic [63:0]             addr_lo,
   output logic                         hit
);

   logic [31:0]  mask_v4;
   logic [127:0] mask_v6;
   logic         eq_v4;
   logic         eq_v6;

   // leading-ones masks; a shift by the full width gives all ones
   always_comb begin
      mask_v4 = ~(32'hFFFF_FFFF >> rule.prefix);
      mask_v6 = ~({128{1'b1}} >> rule.prefix);
      eq_v4   = ((addr_lo[31:0] ^ rule.net_lo[31:0]) & mask_v4) == 32'd0;
      eq_v6   = (({addr_hi, addr_lo} ^ {rule.net_hi, rule.net_lo}) & mask_v6) == 128'd0;
   end

   always_comb begin
      hit = 1'b0;
      case (ctrl.cls)
         caf_pkg::CLS_V4: hit = ctrl.entry_valid && rule.family == caf_pkg::RULE_V4 && eq_v4;
         caf_pkg::CLS_V6: hit = ctrl.entry_valid && rule.family == caf_pkg::RULE_V6 && eq_v6;
         default:         hit = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

/* hdl/cidr_acl_address_filter.sv */
// check: result valid after the scan state (one rule per cycle) and then the drain state
// write: result valid in the cycle after the request transfer
// a new request is taken only once the last response has been taken; the scan is run by
//    the single shared comparator that walks the rule table through one ram read port
// reset is synchronous: clears all rule valid marks and the mode; rule contents are kept
`default_nettype none

`include "assert_macros.svh"

module cidr_acl_address_filter #(
   parameter int RULES = caf_pkg::RULES_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata, low bit up: rule_index[3:0], rule_enable[4], addr_family[6:5],
   // rule_prefix_len[14:7], addr_hi[78:15], addr_lo[142:79], zero pad[143]
   input  wire logic [143:0] req_tdata,
   // tuser: req_type (0 rule write, 1 address check)
   input  wire logic         req_tuser,
   // response channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata, low bit up: allowed[0], matched[1], zero pad[7:2]
   output logic [7:0]        rsp_tdata,
   // mode register write
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_data
);

   localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
   localparam int RULE_W = $bits(caf_pkg::rule_type);

   // request fields
   logic [3:0]  f_index;
   logic        f_enable;
   logic [1:0]  f_family;
   logic [7:0]  f_prefix;
   logic [63:0] f_hi;
   logic [63:0] f_lo;

   assign f_index  = req_tdata[3:0];
   assign f_enable = req_tdata[4];
   assign f_family = req_tdata[6:5];
   assign f_prefix = req_tdata[14:7];
   assign f_hi     = req_tdata[78:15];
   assign f_lo     = req_tdata[142:79];

   // sequencer and datapath registers
   caf_pkg::state_type state_ff, state_in;
   caf_pkg::mode_type  mode_ff, mode_in;
   logic [RULES-1:0]   valid_ff, valid_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic               pipe_ff, pipe_in;      // a ram read is landing this cycle
   logic               ent_valid_ff, ent_valid_in;
   caf_pkg::cls_type   cls_ff, cls_in;
   logic [63:0]        hi_ff, hi_in;
   logic [63:0]        lo_ff, lo_in;
   logic               hit_ff, hit_in;
   logic               rsp_allowed_ff, rsp_allowed_in;
   logic               rsp_matched_ff, rsp_matched_in;

   logic               req_xfer;
   logic               rd_en;
   logic               wr_en;
   logic [8:0]         wide_index;
   logic               in_range;
   logic               rule_keep;
   caf_pkg::rule_type  wr_rule;
   caf_pkg::rule_type  rd_rule;
   logic [RULE_W-1:0]  rd_bits;
   caf_pkg::match_ctrl_type ctrl;
   logic               cmp_hit;
   logic               final_hit;
   logic               mapped;

   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign wide_index = {5'd0, f_index};
   assign in_range   = wide_index < 9'(RULES);
   // an enabled write of a known family loads the entry, anything else clears it
   assign rule_keep  = f_enable && (f_family == caf_pkg::FAM_V4 || f_family == caf_pkg::FAM_V6);
   assign mapped     = (f_hi == 64'd0) && (f_lo[63:32] == caf_pkg::V4_MAPPED_TAG);

   // saturate the prefix per family
   always_comb begin
      wr_rule.family = f_family[0];
      wr_rule.net_hi = f_hi;
      wr_rule.net_lo = f_lo;
      if (f_family == caf_pkg::FAM_V4) begin
         wr_rule.prefix = (f_prefix > caf_pkg::V4_MAX_PREFIX) ? caf_pkg::V4_MAX_PREFIX : f_prefix;
      end else begin
         wr_rule.prefix = (f_prefix > caf_pkg::V6_MAX_PREFIX) ? caf_pkg::V6_MAX_PREFIX : f_prefix;
      end
   end

   assign wr_en = req_xfer && req_tuser == caf_pkg::REQ_WRITE && in_range && rule_keep;

   // rule table: one write port for loads, one read port for the scan
   caf_ram #(
      .WIDTH (RULE_W),
      .DEPTH (RULES)
   ) u_rules (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wide_index[IDX_W-1:0]),
      .wr_data (wr_rule),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff),
      .rd_data (rd_bits)
   );

   assign rd_rule = caf_pkg::rule_type'(rd_bits);

   // shared masked comparator, one rule per cycle
   assign ctrl.entry_valid = pipe_ff && ent_valid_ff;
   assign ctrl.cls         = cls_ff;

   caf_match u_match (
      .ctrl    (ctrl),
      .rule    (rd_rule),
      .addr_hi (hi_ff),
      .addr_lo (lo_ff),
      .hit     (cmp_hit)
   );

   assign final_hit = hit_ff || cmp_hit;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         caf_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = (req_tuser == caf_pkg::REQ_CHECK) ? caf_pkg::ST_SCAN : caf_pkg::ST_RESP;
            end
         end
         caf_pkg::ST_SCAN: begin
            if (cnt_ff == IDX_W'(RULES - 1)) begin
               state_in = caf_pkg::ST_DRAIN;
            end
         end
         caf_pkg::ST_DRAIN: state_in = caf_pkg::ST_RESP;
         caf_pkg::ST_RESP: begin
            if (rsp_tready) begin
               state_in = caf_pkg::ST_IDLE;
            end
         end
         default: state_in = caf_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rd_en      = 1'b0;
      case (state_ff)
         caf_pkg::ST_IDLE:  req_tready = 1'b1;
         caf_pkg::ST_SCAN:  rd_en      = 1'b1;
         caf_pkg::ST_DRAIN: rd_en      = 1'b0;
         caf_pkg::ST_RESP:  rsp_tvalid = 1'b1;
         default:           req_tready = 1'b0;
      endcase
   end

   assign rsp_tdata = {6'd0, rsp_matched_ff, rsp_allowed_ff};

   // datapath next values
   always_comb begin
      mode_in        = mode_ff;
      valid_in       = valid_ff;
      cnt_in         = cnt_ff;
      pipe_in        = rd_en;
      ent_valid_in   = valid_ff[cnt_ff];
      cls_in         = cls_ff;
      hi_in          = hi_ff;
      lo_in          = lo_ff;
      hit_in         = hit_ff;
      rsp_allowed_in = rsp_allowed_ff;
      rsp_matched_in = rsp_matched_ff;

      if (csr_valid && csr_ready) begin
         mode_in = caf_pkg::mode_type'(csr_data);
      end

      if (req_xfer) begin
         if (req_tuser == caf_pkg::REQ_WRITE) begin
            if (in_range) begin
               valid_in[wide_index[IDX_W-1:0]] = rule_keep;
            end
            rsp_allowed_in = 1'b0;
            rsp_matched_in = 1'b0;
         end else begin
            cnt_in = '0;
            hit_in = 1'b0;
            hi_in  = f_hi;
            lo_in  = f_lo;
            // v4-mapped ipv6 goes to the ipv4 rules
            if (f_family == caf_pkg::FAM_V4 || (f_family == caf_pkg::FAM_V6 && mapped)) begin
               cls_in = caf_pkg::CLS_V4;
            end else if (f_family == caf_pkg::FAM_V6) begin
               cls_in = caf_pkg::CLS_V6;
            end else begin
               cls_in = caf_pkg::CLS_NONE;
            end
         end
      end

      if (state_ff == caf_pkg::ST_SCAN) begin
         cnt_in = cnt_ff + IDX_W'(1);
         hit_in = final_hit;
      end

      // last compare lands here, mode turns the match into an answer
      if (state_ff == caf_pkg::ST_DRAIN) begin
         hit_in         = final_hit;
         rsp_matched_in = final_hit;
         case (mode_ff)
            caf_pkg::MODE_ALLOW_EXCEPT: rsp_allowed_in = !final_hit;
            caf_pkg::MODE_DENY_EXCEPT:  rsp_allowed_in = final_hit;
            default:                    rsp_allowed_in = 1'b1;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= caf_pkg::ST_IDLE;
         mode_ff  <= caf_pkg::MODE_DISABLED;
         valid_ff <= '0;
         pipe_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         valid_ff <= valid_in;
         pipe_ff  <= pipe_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      ent_valid_ff   <= ent_valid_in;
      cls_ff         <= cls_in;
      hi_ff          <= hi_in;
      lo_ff          <= lo_in;
      hit_ff         <= hit_in;
      rsp_allowed_ff <= rsp_allowed_in;
      rsp_matched_ff <= rsp_matched_in;
   end

   // checks
   `ASSERT_NOW(a_no_overlap, clock, reset, req_tready, !rsp_tvalid, "request taken while a response is pending")
   `ASSERT_NEXT(a_check_scans, clock, reset, req_xfer && req_tuser == caf_pkg::REQ_CHECK, state_ff == caf_pkg::ST_SCAN, "check did not start a scan")
   `ASSERT_NEXT(a_write_resp, clock, reset, req_xfer && req_tuser == caf_pkg::REQ_WRITE, rsp_tvalid && rsp_tdata == 8'd0, "write response missing or not zero")
   `ASSERT_NEXT(a_drain_resp, clock, reset, state_ff == caf_pkg::ST_DRAIN, rsp_tvalid, "scan end did not raise a response")
   `ASSERT_NOW(a_none_no_match, clock, reset, rsp_tvalid && cls_ff == caf_pkg::CLS_NONE && !$past(req_xfer), !rsp_tdata[1], "other family reported a match")

endmodule

`default_nettype wire

/* verif/cidr_acl_address_filter_test.sv */
`default_nettype none

module cidr_acl_address_filter_test;

   localparam int RULES = caf_pkg::RULES_DEFAULT;

   // families that have no name in the package: both count as "other"
   localparam logic [1:0] FAM_OTHER    = 2'd2;
   localparam logic [1:0] FAM_RESERVED = 2'd3;

   localparam int PHASE_ITEMS = 150;
   localparam int PHASES      = 6;

   // one request as it travels on req_tdata and req_tuser
   typedef struct {
      logic        kind;
      logic [3:0]  idx;
      logic        en;
      logic [1:0]  fam;
      logic [7:0]  plen;
      logic [63:0] hi;
      logic [63:0] lo;
   } acl_request_type;

   typedef struct {
      logic allowed;
      logic matched;
   } acl_verdict_type;

   // directed rows: a request with a hand-written answer, a request left to
   // the local filter model, or a mode change made while the block is idle
   typedef enum {
      ROW_FIXED,
      ROW_PREDICTED,
      ROW_MODE
   } row_action_type;

   typedef struct {
      row_action_type    action;
      caf_pkg::mode_type mode;
      acl_request_type   req;
      acl_verdict_type   want;
   } stim_row_type;

   typedef struct {
      logic            fixed;
      acl_verdict_type want;
   } fixed_answer_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata  = '0;
   logic         req_tuser  = caf_pkg::REQ_WRITE;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_data   = caf_pkg::MODE_DISABLED;

   // local copy of the rule table and the mode register
   caf_pkg::mode_type filter_mode;
   logic              rule_live [RULES];
   logic              rule_v6   [RULES];
   logic [7:0]        rule_len  [RULES];
   logic [127:0]      rule_net  [RULES];

   acl_verdict_type  pending_verdicts[$];
   fixed_answer_type fixed_answers[$];
   int               mismatch_count = 0;
   int               burst_left     = 0;

   // receiver stall pattern state
   int rx_style = 0;
   int rx_left  = 0;

   cidr_acl_address_filter #(
      .RULES (RULES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // network masks: top p bits set, zero length gives an empty mask
   function automatic logic [31:0] v4_mask(input int p);
      return (p == 0) ? 32'h0 : ({32{1'b1}} << (32 - p));
   endfunction

   function automatic logic [127:0] v6_mask(input int p);
      return (p == 0) ? 128'h0 : ({128{1'b1}} << (128 - p));
   endfunction

   // applies one accepted request to the local rule table and works out the answer
   function automatic acl_verdict_type screen_request(input acl_request_type r);
      acl_verdict_type v;
      logic            hit;
      logic            mapped;
      logic [31:0]     m4;
      logic [127:0]    m6;
      v.allowed = 1'b0;
      v.matched = 1'b0;
      if (r.kind == caf_pkg::REQ_WRITE) begin
         // a disabled write or one of another family clears the entry
         if (r.en && (r.fam == caf_pkg::FAM_V4 || r.fam == caf_pkg::FAM_V6)) begin
            rule_live[r.idx] = 1'b1;
            rule_v6[r.idx]   = (r.fam == caf_pkg::FAM_V6) ? caf_pkg::RULE_V6
                                                          : caf_pkg::RULE_V4;
            if (r.fam == caf_pkg::FAM_V4)
               rule_len[r.idx] = (r.plen > caf_pkg::V4_MAX_PREFIX) ? caf_pkg::V4_MAX_PREFIX
                                                                   : r.plen;
            else
               rule_len[r.idx] = (r.plen > caf_pkg::V6_MAX_PREFIX) ? caf_pkg::V6_MAX_PREFIX
                                                                   : r.plen;
            rule_net[r.idx] = {r.hi, r.lo};
         end else begin
            rule_live[r.idx] = 1'b0;
         end
         return v;
      end
      hit    = 1'b0;
      mapped = (r.fam == caf_pkg::FAM_V6) && (r.hi == 64'h0) &&
               (r.lo[63:32] == caf_pkg::V4_MAPPED_TAG);
      for (int i = 0; i < RULES; i++) begin
         if (rule_live[i]) begin
            m4 = v4_mask(int'(rule_len[i]));
            m6 = v6_mask(int'(rule_len[i]));
            // ipv4 rules only look at the low 32 bits of the stored network
            if ((r.fam == caf_pkg::FAM_V4 || mapped) && rule_v6[i] == caf_pkg::RULE_V4 &&
                ((r.lo[31:0] ^ rule_net[i][31:0]) & m4) == 32'h0)
               hit = 1'b1;
            if (r.fam == caf_pkg::FAM_V6 && !mapped && rule_v6[i] == caf_pkg::RULE_V6 &&
                (({r.hi, r.lo} ^ rule_net[i]) & m6) == 128'h0)
               hit = 1'b1;
         end
      end
      v.matched = hit;
      case (filter_mode)
         caf_pkg::MODE_ALLOW_EXCEPT: v.allowed = !hit;
         caf_pkg::MODE_DENY_EXCEPT:  v.allowed = hit;
         default:                    v.allowed = 1'b1;
      endcase
      return v;
   endfunction

   // random request: mostly checks aimed at live rules, hits and near misses alike
   function automatic acl_request_type random_request();
      acl_request_type r;
      int              pick;
      int              i;
      int              p;
      logic [31:0]     a4;
      logic [127:0]    a6;
      r.kind = caf_pkg::REQ_CHECK;
      r.idx  = 4'($urandom);
      r.en   = 1'($urandom);
      r.fam  = 2'($urandom);
      r.plen = 8'($urandom);
      r.hi   = {$urandom, $urandom};
      r.lo   = {$urandom, $urandom};
      pick   = $urandom_range(0, 99);
      i      = $urandom_range(0, RULES - 1);
      if (pick < 25) begin
         // rule write
         r.kind = caf_pkg::REQ_WRITE;
         r.en   = ($urandom_range(0, 7) != 0);
         case ($urandom_range(0, 9))
            0:          r.fam = 2'($urandom_range(FAM_OTHER, FAM_RESERVED));
            1, 2, 3, 4: r.fam = caf_pkg::FAM_V4;
            default:    r.fam = caf_pkg::FAM_V6;
         endcase
         // mostly legal lengths, now and then an over-long one
         if ($urandom_range(0, 4) != 0)
            r.plen = (r.fam == caf_pkg::FAM_V4) ? 8'($urandom_range(0, caf_pkg::V4_MAX_PREFIX))
                                                : 8'($urandom_range(0, caf_pkg::V6_MAX_PREFIX));
      end else if (pick < 90 && rule_live[i]) begin
         p = int'(rule_len[i]);
         if (rule_v6[i] == caf_pkg::RULE_V4) begin
            a4 = (rule_net[i][31:0] & v4_mask(p)) | ($urandom & ~v4_mask(p));
            if (p > 0 && $urandom_range(0, 2) == 0)
               a4 ^= 32'h1 << (32 - $urandom_range(1, p));
            // plain ipv4 or the v4-mapped ipv6 form
            if ($urandom_range(0, 1) == 0) begin
               r.fam   = caf_pkg::FAM_V4;
               r.lo[31:0] = a4;
            end else begin
               r.fam = caf_pkg::FAM_V6;
               r.hi  = 64'h0;
               r.lo  = {caf_pkg::V4_MAPPED_TAG, a4};
            end
         end else begin
            a6 = (rule_net[i] & v6_mask(p)) | ({r.hi, r.lo} & ~v6_mask(p));
            if (p > 0 && $urandom_range(0, 2) == 0)
               a6 ^= 128'h1 << (128 - $urandom_range(1, p));
            r.fam = caf_pkg::FAM_V6;
            {r.hi, r.lo} = a6;
         end
      end else if ($urandom_range(0, 3) == 0) begin
         // mapped-looking address under any family
         r.hi        = 64'h0;
         r.lo[63:32] = caf_pkg::V4_MAPPED_TAG;
      end
      return r;
   endfunction

   function automatic acl_request_type acl_req(input logic kind, input logic [3:0] idx,
                                               input logic en, input logic [1:0] fam,
                                               input logic [7:0] plen,
                                               input logic [63:0] hi,
                                               input logic [63:0] lo);
      acl_request_type r;
      r.kind = kind;
      r.idx  = idx;
      r.en   = en;
      r.fam  = fam;
      r.plen = plen;
      r.hi   = hi;
      r.lo   = lo;
      return r;
   endfunction

   function automatic stim_row_type fixed_row(input acl_request_type r, input logic allowed,
                                              input logic matched);
      stim_row_type s;
      s.action       = ROW_FIXED;
      s.mode         = caf_pkg::MODE_DISABLED;
      s.req          = r;
      s.want.allowed = allowed;
      s.want.matched = matched;
      return s;
   endfunction

   function automatic stim_row_type predicted_row(input acl_request_type r);
      stim_row_type s;
      s = fixed_row(r, 1'b0, 1'b0);
      s.action = ROW_PREDICTED;
      return s;
   endfunction

   function automatic stim_row_type mode_row(input caf_pkg::mode_type m);
      stim_row_type s;
      s = fixed_row(acl_req(caf_pkg::REQ_CHECK, 4'd0, 1'b0, caf_pkg::FAM_V4, 8'd0,
                            64'h0, 64'h0), 1'b0, 1'b0);
      s.action = ROW_MODE;
      s.mode   = m;
      return s;
   endfunction

   // one request transfer, called and returning at a falling edge;
   // the sender runs in bursts with random gaps, some gaps empty
   task automatic send_request(input acl_request_type r, input logic fixed,
                               input acl_verdict_type want);
      fixed_answer_type note;
      int               gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      note.fixed = fixed;
      note.want  = want;
      fixed_answers.push_back(note);
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {1'b0, r.lo, r.hi, r.plen, r.fam, r.en, r.idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // mode change: only once every outstanding answer has come back
   task automatic set_mode(input caf_pkg::mode_type m);
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver: stretches of full rate, coin-flip stalls, heavy stalls and a
   // periodic one-in-eight stall, each held for a random spell
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_style <= $urandom_range(0, 3);
         rx_left  <= $urandom_range(20, 200);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_style)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 1) == 0);
         2:       rsp_tready <= ($urandom_range(0, 5) == 0);
         default: rsp_tready <= (rx_left[2:0] != 3'd0);
      endcase
   end

   // transfer monitor: answers are checked against the oldest expectation,
   // requests update the local table at the edge where they are taken
   always @(posedge clock) begin
      acl_request_type  r;
      acl_verdict_type  want;
      fixed_answer_type note;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_verdicts.size() == 0) begin
               $error("response transfer with no request outstanding");
               mismatch_count++;
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_tdata[0] !== want.allowed) begin
                  $error("allowed: expected %0b, got %0b", want.allowed, rsp_tdata[0]);
                  mismatch_count++;
               end
               if (rsp_tdata[1] !== want.matched) begin
                  $error("matched: expected %0b, got %0b", want.matched, rsp_tdata[1]);
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready)
            filter_mode = caf_pkg::mode_type'(csr_data);
         if (req_tvalid && req_tready) begin
            r.kind = req_tuser;
            r.idx  = req_tdata[3:0];
            r.en   = req_tdata[4];
            r.fam  = req_tdata[6:5];
            r.plen = req_tdata[14:7];
            r.hi   = req_tdata[78:15];
            r.lo   = req_tdata[142:79];
            want   = screen_request(r);
            note   = fixed_answers.pop_front();
            if (note.fixed)
               want = note.want;
            pending_verdicts.push_back(want);
         end
      end
   end

   initial begin
      stim_row_type      directed_rows[$];
      acl_verdict_type   none;
      caf_pkg::mode_type phase_modes[4];
      none.allowed   = 1'b0;
      none.matched   = 1'b0;
      phase_modes[0] = caf_pkg::MODE_ALLOW_EXCEPT;
      phase_modes[1] = caf_pkg::MODE_DENY_EXCEPT;
      phase_modes[2] = caf_pkg::MODE_DISABLED;
      phase_modes[3] = caf_pkg::MODE_UNKNOWN;
      filter_mode    = caf_pkg::MODE_DISABLED;
      foreach (rule_live[i])
         rule_live[i] = 1'b0;

      // empty table, mode disabled: everything allowed, nothing matched
      directed_rows.push_back(fixed_row(acl_req(caf_pkg::REQ_CHECK, 4'd0, 1'b0,
                                                caf_pkg::FAM_V4, 8'd0,
                                                64'h0, 64'h0), 1'b1, 1'b0));
      directed_rows.push_back(fixed_row(acl_req(caf_pkg::REQ_CHECK, 4'hF, 1'b1,
                                                caf_pkg::FAM_V6, 8'hFF,
                                                '1, '1), 1'b1, 1'b0));
      directed_rows.push_back(fixed_row(acl_req(caf_pkg::REQ_CHECK, 4'd0, 1'b0,
                                                FAM_OTHER, 8'd0,
                                                64'h0, 64'h0), 1'b1, 1'b0));
      // rule writes always answer with both bits low
      directed_rows.push_back(fixed_row(acl_req(caf_pkg::REQ_WRITE, 4'd0, 1'b1,
                                                caf_pkg::FAM_V4, 8'd8,
                                                64'h0, 64'h0A00_0000), 1'b0, 1'b0));
      // over-long ipv4 length, network high word left as written
      directed_rows.push_back(fixed_row(acl_req(caf_pkg::REQ_WRITE, 4'hF, 1'b1,
                                                caf_pkg::FAM_V4, 8'hFF,
                                                '1, '1), 1'b0, 1'b0));
      // over-long ipv6 length
      directed_rows.push_back(fixed_row(acl_req(caf_pkg::REQ_WRITE, 4'd1, 1'b1,
                                                caf_pkg::FAM_V6, 8'hFF,
                                                '1, '1), 1'b0, 1'b0));
      // zero length: matches every ipv6 address that is not v4-mapped
      directed_rows.push_back(fixed_row(acl_req(caf_pkg::REQ_WRITE, 4'd2, 1'b1,
                                                caf_pkg::FAM_V6, 8'd0,
                                                64'h1234, 64'h5678), 1'b0, 1'b0));
      directed_rows.push_back(fixed_row(acl_req(caf_pkg::REQ_WRITE, 4'd3, 1'b1,
                                                caf_pkg::FAM_V6, 8'd64,
                                                64'h2001_0DB8_0000_0000, 64'h0),
                                        1'b0, 1'b0));
      // rule of another family clears the entry
      directed_rows.push_back(fixed_row(acl_req(caf_pkg::REQ_WRITE, 4'd4, 1'b1,
                                                FAM_OTHER, 8'd16,
                                                64'h0, 64'h0A00_0000), 1'b0, 1'b0));
      directed_rows.push_back(fixed_row(acl_req(caf_pkg::REQ_WRITE, 4'd5, 1'b0,
                                                caf_pkg::FAM_V4, 8'd0,
                                                64'h0, 64'h0), 1'b0, 1'b0));
      directed_rows.push_back(predicted_row(acl_req(caf_pkg::REQ_CHECK, 4'd0, 1'b0,
                                                    caf_pkg::FAM_V4, 8'd0,
                                                    64'h0, 64'h0A01_0203)));
      directed_rows.push_back(predicted_row(acl_req(caf_pkg::REQ_CHECK, 4'd0, 1'b0,
                                                    caf_pkg::FAM_V4, 8'd0,
                                                    64'h0, 64'hFFFF_FFFF)));
      // v4-mapped ipv6 against the ipv4 rules
      directed_rows.push_back(predicted_row(acl_req(caf_pkg::REQ_CHECK, 4'd0, 1'b0,
                                                    caf_pkg::FAM_V6, 8'd0,
                                                    64'h0, 64'h0000_FFFF_0A09_0909)));
      directed_rows.push_back(predicted_row(acl_req(caf_pkg::REQ_CHECK, 4'd0, 1'b0,
                                                    caf_pkg::FAM_V6, 8'd0,
                                                    64'h0, 64'h1)));
      directed_rows.push_back(fixed_row(acl_req(caf_pkg::REQ_WRITE, 4'd2, 1'b0,
                                                caf_pkg::FAM_V6, 8'd0,
                                                64'h0, 64'h0), 1'b0, 1'b0));
      directed_rows.push_back(predicted_row(acl_req(caf_pkg::REQ_CHECK, 4'd0, 1'b0,
                                                    caf_pkg::FAM_V6, 8'd0,
                                                    64'h0, 64'h1)));
      directed_rows.push_back(predicted_row(acl_req(caf_pkg::REQ_CHECK, 4'd0, 1'b0,
                                                    caf_pkg::FAM_V6, 8'd0,
                                                    64'h2001_0DB8_0000_0000,
                                                    64'hDEAD_BEEF_0000_0001)));
      directed_rows.push_back(predicted_row(acl_req(caf_pkg::REQ_CHECK, 4'd0, 1'b0,
                                                    caf_pkg::FAM_V6, 8'd0,
                                                    64'h2001_0DB9_0000_0000, 64'h0)));
      directed_rows.push_back(mode_row(caf_pkg::MODE_ALLOW_EXCEPT));
      directed_rows.push_back(predicted_row(acl_req(caf_pkg::REQ_CHECK, 4'd0, 1'b0,
                                                    caf_pkg::FAM_V6, 8'd0,
                                                    '1, '1)));
      directed_rows.push_back(predicted_row(acl_req(caf_pkg::REQ_CHECK, 4'd0, 1'b0,
                                                    caf_pkg::FAM_V6, 8'd0,
                                                    '1, 64'hFFFF_FFFF_FFFF_FFFE)));
      // another family never matches, whatever the address
      directed_rows.push_back(fixed_row(acl_req(caf_pkg::REQ_CHECK, 4'd0, 1'b0,
                                                FAM_RESERVED, 8'd0,
                                                64'h0, 64'h0A00_0001), 1'b1, 1'b0));
      directed_rows.push_back(mode_row(caf_pkg::MODE_DENY_EXCEPT));
      // ipv4 check ignores the high word and the top of the low word
      directed_rows.push_back(predicted_row(acl_req(caf_pkg::REQ_CHECK, 4'd0, 1'b0,
                                                    caf_pkg::FAM_V4, 8'd0,
                                                    '1, 64'h1234_5678_0A0B_0C0D)));
      directed_rows.push_back(fixed_row(acl_req(caf_pkg::REQ_CHECK, 4'd0, 1'b0,
                                                FAM_OTHER, 8'd0,
                                                64'h0, 64'h0A00_0001), 1'b0, 1'b0));
      directed_rows.push_back(predicted_row(acl_req(caf_pkg::REQ_CHECK, 4'd0, 1'b0,
                                                    caf_pkg::FAM_V4, 8'd0,
                                                    64'h0, 64'h0B00_0000)));
      directed_rows.push_back(mode_row(caf_pkg::MODE_UNKNOWN));
      directed_rows.push_back(predicted_row(acl_req(caf_pkg::REQ_CHECK, 4'd0, 1'b0,
                                                    caf_pkg::FAM_V4, 8'd0,
                                                    64'h0, 64'h0A00_0000)));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         if (directed_rows[k].action == ROW_MODE)
            set_mode(directed_rows[k].mode);
         else
            send_request(directed_rows[k].req, directed_rows[k].action == ROW_FIXED,
                         directed_rows[k].want);
      end

      // random phases, each under its own mode; the first four visit every mode
      for (int ph = 0; ph < PHASES; ph++) begin
         set_mode((ph < 4) ? phase_modes[ph]
                           : caf_pkg::mode_type'($urandom_range(0, 3)));
         repeat (PHASE_ITEMS)
            send_request(random_request(), 1'b0, none);
      end

      // drain, then wait out any stray transfers
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (RULES + 8) @(posedge clock);
      if (mismatch_count == 0)
         $display("[cidr_acl_address_filter] OK");
      else
         $display("[cidr_acl_address_filter] ERROR");
      $finish;
   end

   // hang guard, several times the slowest legal run
   initial begin
      #5_000_000;
      $display("[cidr_acl_address_filter] ERROR");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+hdl
hdl/caf_pkg.sv
hdl/caf_ram.sv
hdl/caf_match.sv
hdl/cidr_acl_address_filter.sv
verif/cidr_acl_address_filter_test.sv
